// ===== rtl/apfe_pkg.sv =====
`timescale 1ns / 1ps
package apfe_pkg;

  localparam int SAMPLE_W     = 10;
  localparam int SAMPLE_TOP   = (1 << SAMPLE_W) - 1;
  localparam int CHAN_W       = 6;
  localparam int THR_W        = 8;
  localparam int STATUS_W     = 2;
  localparam int BASE_OUT_W   = 13;
  localparam int SPREAD_OUT_W = 25;
  localparam int NET_OUT_W    = 19;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 8;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX     = '1;
  localparam logic [CHAN_W-1:0]   ACTIVE_CH_RST  = 6'd63;
  localparam logic [THR_W-1:0]    PILEUP_THR_RST = 8'd6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_CH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PILEUP_THR = 2'd1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_BAD_CHANNEL = 2'd1,
    ST_WRONG_LEN   = 2'd2
  } status_t;

  // one sample word after the squaring stage
  typedef struct packed {
    logic [CHAN_W-1:0]     chan;
    logic [SAMPLE_W-1:0]   sample;
    logic                  last_sample;
    logic [2*SAMPLE_W-1:0] sq;
  } front_word_t;

endpackage

// ===== rtl/adc_pulse_feature_extractor.sv =====
`timescale 1ns / 1ps
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    in_channel, in_sample, in_last_sample
// out      output     out_valid / out_ready  out_pulse_channel, out_status, out_peak,
//                                            out_floor, out_baseline_sum,
//                                            out_spread_scaled, out_net_area_scaled,
//                                            out_pileup
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one sample word per clock while in_ready is high; the running sums close in a single register loop
// after its last word is accepted, a result passes the input, square, totals, multiply
// and output registers before it shows on the output
// reset clears all stage valids and pulse sums, config returns to 63 and 6
// out_ready low fills the stages behind the output register before in_ready drops
// cfg_ready is always high
module adc_pulse_feature_extractor
  import apfe_pkg::*;
#(
  parameter int SAMPLES_PER_PULSE = 32,
  parameter int BASELINE_WINDOW   = 5,
  localparam int CNT_W  = $clog2(SAMPLES_PER_PULSE + 2),
  localparam int BASE_W = $clog2(BASELINE_WINDOW * SAMPLE_TOP + 1),
  localparam int SQ_W   = $clog2(BASELINE_WINDOW * SAMPLE_TOP * SAMPLE_TOP + 1),
  localparam int AREA_W = $clog2(SAMPLES_PER_PULSE * SAMPLE_TOP + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [CHAN_W-1:0]           in_channel,
  input  logic [SAMPLE_W-1:0]         in_sample,
  input  logic                        in_last_sample,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [CHAN_W-1:0]           out_pulse_channel,
  output logic [STATUS_W-1:0]         out_status,
  output logic [SAMPLE_W-1:0]         out_peak,
  output logic [SAMPLE_W-1:0]         out_floor,
  output logic [BASE_OUT_W-1:0]       out_baseline_sum,
  output logic [SPREAD_OUT_W-1:0]     out_spread_scaled,
  output logic signed [NET_OUT_W-1:0] out_net_area_scaled,
  output logic                        out_pileup,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data
);

  logic [CHAN_W-1:0]   active_ch_r;
  logic [THR_W-1:0]    pileup_thr_r;
  logic                word_valid;
  logic                word_ready;
  front_word_t         word;
  logic                snap_valid;
  logic                snap_ready;
  logic [CHAN_W-1:0]   snap_chan;
  logic [CNT_W-1:0]    snap_count;
  logic [SAMPLE_W-1:0] snap_peak;
  logic [SAMPLE_W-1:0] snap_floor;
  logic [BASE_W-1:0]   snap_base;
  logic [SQ_W-1:0]     snap_sq;
  logic [AREA_W-1:0]   snap_area;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_ch_r  <= ACTIVE_CH_RST;
      pileup_thr_r <= PILEUP_THR_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ACTIVE_CH:  active_ch_r  <= cfg_data[CHAN_W-1:0];
        CFG_PILEUP_THR: pileup_thr_r <= cfg_data[THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  apfe_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_channel     (in_channel),
    .in_sample      (in_sample),
    .in_last_sample (in_last_sample),
    .word_valid     (word_valid),
    .word_ready     (word_ready),
    .word           (word)
  );

  apfe_accum #(
    .SAMPLES_PER_PULSE (SAMPLES_PER_PULSE),
    .BASELINE_WINDOW   (BASELINE_WINDOW)
  ) u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .word_valid (word_valid),
    .word_ready (word_ready),
    .word       (word),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap_chan  (snap_chan),
    .snap_count (snap_count),
    .snap_peak  (snap_peak),
    .snap_floor (snap_floor),
    .snap_base  (snap_base),
    .snap_sq    (snap_sq),
    .snap_area  (snap_area)
  );

  apfe_final #(
    .SAMPLES_PER_PULSE (SAMPLES_PER_PULSE),
    .BASELINE_WINDOW   (BASELINE_WINDOW)
  ) u_final (
    .clk                 (clk),
    .rst_n               (rst_n),
    .snap_valid          (snap_valid),
    .snap_ready          (snap_ready),
    .snap_chan           (snap_chan),
    .snap_count          (snap_count),
    .snap_peak           (snap_peak),
    .snap_floor          (snap_floor),
    .snap_base           (snap_base),
    .snap_sq             (snap_sq),
    .snap_area           (snap_area),
    .active_channels     (active_ch_r),
    .pileup_threshold    (pileup_thr_r),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_pulse_channel   (out_pulse_channel),
    .out_status          (out_status),
    .out_peak            (out_peak),
    .out_floor           (out_floor),
    .out_baseline_sum    (out_baseline_sum),
    .out_spread_scaled   (out_spread_scaled),
    .out_net_area_scaled (out_net_area_scaled),
    .out_pileup          (out_pileup)
  );

endmodule

// ===== rtl/apfe_front.sv =====
`timescale 1ns / 1ps
module apfe_front
  import apfe_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CHAN_W-1:0]   in_channel,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  logic                in_last_sample,
  output logic                word_valid,
  input  logic                word_ready,
  output front_word_t         word
);

  logic                v1_r;
  logic [CHAN_W-1:0]   ch1_r;
  logic [SAMPLE_W-1:0] s1_r;
  logic                last1_r;
  logic                v2_r;
  front_word_t         word_r;
  logic                rdy2;
  logic                mv1;
  logic                in_fire;

  assign rdy2     = !v2_r || word_ready;
  assign mv1      = v1_r && rdy2;
  assign in_ready = !v1_r || rdy2;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (in_fire) begin
        v1_r <= 1'b1;
      end else if (mv1) begin
        v1_r <= 1'b0;
      end
      if (mv1) begin
        v2_r <= 1'b1;
      end else if (word_ready) begin
        v2_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ch1_r   <= in_channel;
      s1_r    <= in_sample;
      last1_r <= in_last_sample;
    end
    if (mv1) begin
      word_r.chan        <= ch1_r;
      word_r.sample      <= s1_r;
      word_r.last_sample <= last1_r;
      word_r.sq          <= (2*SAMPLE_W)'(s1_r) * (2*SAMPLE_W)'(s1_r);
    end
  end

  assign word_valid = v2_r;
  assign word       = word_r;

endmodule

// ===== rtl/apfe_accum.sv =====
`timescale 1ns / 1ps
module apfe_accum
  import apfe_pkg::*;
#(
  parameter int SAMPLES_PER_PULSE = 32,
  parameter int BASELINE_WINDOW   = 5,
  localparam int CNT_W  = $clog2(SAMPLES_PER_PULSE + 2),
  localparam int BASE_W = $clog2(BASELINE_WINDOW * SAMPLE_TOP + 1),
  localparam int SQ_W   = $clog2(BASELINE_WINDOW * SAMPLE_TOP * SAMPLE_TOP + 1),
  localparam int AREA_W = $clog2(SAMPLES_PER_PULSE * SAMPLE_TOP + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                word_valid,
  output logic                word_ready,
  input  front_word_t         word,
  output logic                snap_valid,
  input  logic                snap_ready,
  output logic [CHAN_W-1:0]   snap_chan,
  output logic [CNT_W-1:0]    snap_count,
  output logic [SAMPLE_W-1:0] snap_peak,
  output logic [SAMPLE_W-1:0] snap_floor,
  output logic [BASE_W-1:0]   snap_base,
  output logic [SQ_W-1:0]     snap_sq,
  output logic [AREA_W-1:0]   snap_area
);

  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [BASE_W-1:0]   base_r, base_nxt;
  logic [SQ_W-1:0]     sq_r, sq_nxt;
  logic [AREA_W-1:0]   area_r, area_nxt;
  logic [SAMPLE_W-1:0] peak_r, peak_nxt;
  logic [SAMPLE_W-1:0] floor_r, floor_nxt;
  logic                snap_v_r;
  logic [CHAN_W-1:0]   snap_chan_r;
  logic [CNT_W-1:0]    snap_count_r;
  logic [SAMPLE_W-1:0] snap_peak_r;
  logic [SAMPLE_W-1:0] snap_floor_r;
  logic [BASE_W-1:0]   snap_base_r;
  logic [SQ_W-1:0]     snap_sq_r;
  logic [AREA_W-1:0]   snap_area_r;
  logic                in_len;
  logic                in_win;
  logic                snap_rdy;
  logic                take;

  assign snap_rdy   = !snap_v_r || snap_ready;
  assign word_ready = !word.last_sample || snap_rdy;
  assign take       = word_valid && word_ready;

  always_comb begin
    in_len    = 32'(count_r) < SAMPLES_PER_PULSE;
    in_win    = 32'(count_r) < BASELINE_WINDOW;
    count_nxt = count_r;
    base_nxt  = base_r;
    sq_nxt    = sq_r;
    area_nxt  = area_r;
    peak_nxt  = peak_r;
    floor_nxt = floor_r;
    // samples past the nominal length only bump the count, which saturates one above it
    if (in_len) begin
      if (in_win) begin
        base_nxt = base_r + BASE_W'(word.sample);
        sq_nxt   = sq_r + SQ_W'(word.sq);
      end
      area_nxt = area_r + AREA_W'(word.sample);
      if (peak_r <= word.sample) begin
        peak_nxt = word.sample;
      end
      if (floor_r >= word.sample) begin
        floor_nxt = word.sample;
      end
    end
    if (32'(count_r) < SAMPLES_PER_PULSE + 1) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      base_r   <= '0;
      sq_r     <= '0;
      area_r   <= '0;
      peak_r   <= '0;
      floor_r  <= SAMPLE_MAX;
      snap_v_r <= 1'b0;
    end else begin
      if (take) begin
        if (word.last_sample) begin
          count_r <= '0;
          base_r  <= '0;
          sq_r    <= '0;
          area_r  <= '0;
          peak_r  <= '0;
          floor_r <= SAMPLE_MAX;
        end else begin
          count_r <= count_nxt;
          base_r  <= base_nxt;
          sq_r    <= sq_nxt;
          area_r  <= area_nxt;
          peak_r  <= peak_nxt;
          floor_r <= floor_nxt;
        end
      end
      if (take && word.last_sample) begin
        snap_v_r <= 1'b1;
      end else if (snap_ready) begin
        snap_v_r <= 1'b0;
      end
    end
  end

  // totals including the closing word
  always_ff @(posedge clk) begin
    if (take && word.last_sample) begin
      snap_chan_r  <= word.chan;
      snap_count_r <= count_nxt;
      snap_peak_r  <= peak_nxt;
      snap_floor_r <= floor_nxt;
      snap_base_r  <= base_nxt;
      snap_sq_r    <= sq_nxt;
      snap_area_r  <= area_nxt;
    end
  end

  assign snap_valid = snap_v_r;
  assign snap_chan  = snap_chan_r;
  assign snap_count = snap_count_r;
  assign snap_peak  = snap_peak_r;
  assign snap_floor = snap_floor_r;
  assign snap_base  = snap_base_r;
  assign snap_sq    = snap_sq_r;
  assign snap_area  = snap_area_r;

  a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= SAMPLES_PER_PULSE + 1)
    else $error("sample count past saturation");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    take && word.last_sample |=> count_r == '0 && base_r == '0 && floor_r == SAMPLE_MAX)
    else $error("pulse state not cleared after last word");

endmodule

// ===== rtl/apfe_final.sv =====
`timescale 1ns / 1ps
module apfe_final
  import apfe_pkg::*;
#(
  parameter int SAMPLES_PER_PULSE = 32,
  parameter int BASELINE_WINDOW   = 5,
  localparam int CNT_W     = $clog2(SAMPLES_PER_PULSE + 2),
  localparam int BASE_W    = $clog2(BASELINE_WINDOW * SAMPLE_TOP + 1),
  localparam int SQ_W      = $clog2(BASELINE_WINDOW * SAMPLE_TOP * SAMPLE_TOP + 1),
  localparam int AREA_W    = $clog2(SAMPLES_PER_PULSE * SAMPLE_TOP + 1),
  localparam int WQ_W      = $clog2(BASELINE_WINDOW * BASELINE_WINDOW
                                    * SAMPLE_TOP * SAMPLE_TOP + 1),
  localparam int NET_W     = $clog2(BASELINE_WINDOW * SAMPLES_PER_PULSE * SAMPLE_TOP + 1) + 1,
  localparam int NET_MAG_W = NET_W - 1,
  localparam int THR_SC_W  = THR_W + $clog2(BASELINE_WINDOW * BASELINE_WINDOW + 1),
  localparam int CMP_W     = (WQ_W > THR_SC_W) ? WQ_W : THR_SC_W
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        snap_valid,
  output logic                        snap_ready,
  input  logic [CHAN_W-1:0]           snap_chan,
  input  logic [CNT_W-1:0]            snap_count,
  input  logic [SAMPLE_W-1:0]         snap_peak,
  input  logic [SAMPLE_W-1:0]         snap_floor,
  input  logic [BASE_W-1:0]           snap_base,
  input  logic [SQ_W-1:0]             snap_sq,
  input  logic [AREA_W-1:0]           snap_area,
  input  logic [CHAN_W-1:0]           active_channels,
  input  logic [THR_W-1:0]            pileup_threshold,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [CHAN_W-1:0]           out_pulse_channel,
  output logic [STATUS_W-1:0]         out_status,
  output logic [SAMPLE_W-1:0]         out_peak,
  output logic [SAMPLE_W-1:0]         out_floor,
  output logic [BASE_OUT_W-1:0]       out_baseline_sum,
  output logic [SPREAD_OUT_W-1:0]     out_spread_scaled,
  output logic signed [NET_OUT_W-1:0] out_net_area_scaled,
  output logic                        out_pileup
);

  logic                        v4_r;
  status_t                     stat4_r;
  logic [CHAN_W-1:0]           chan4_r;
  logic [SAMPLE_W-1:0]         peak4_r;
  logic [SAMPLE_W-1:0]         floor4_r;
  logic [BASE_W-1:0]           base4_r;
  logic [WQ_W-1:0]             wq4_r;
  logic [WQ_W-1:0]             ss4_r;
  logic signed [NET_W-1:0]     net4_r;
  logic                        out_valid_r;
  logic [CHAN_W-1:0]           out_chan_r;
  status_t                     out_status_r;
  logic [SAMPLE_W-1:0]         out_peak_r;
  logic [SAMPLE_W-1:0]         out_floor_r;
  logic [BASE_OUT_W-1:0]       out_base_r;
  logic [SPREAD_OUT_W-1:0]     out_spread_r;
  logic signed [NET_OUT_W-1:0] out_net_r;
  logic                        out_pileup_r;
  logic                        rdy_o;
  logic                        rdy4;
  logic                        mv3;
  logic                        mv4;
  status_t                     status_c;
  logic [NET_MAG_W-1:0]        wt_c;
  logic [NET_MAG_W-1:0]        sp_c;
  logic signed [NET_W-1:0]     net_c;
  logic [WQ_W-1:0]             spread_c;
  logic [THR_SC_W-1:0]         thr_sc_c;
  logic                        pile_c;

  assign rdy_o      = !out_valid_r || out_ready;
  assign rdy4       = !v4_r || rdy_o;
  assign snap_ready = rdy4;
  assign mv3        = snap_valid && rdy4;
  assign mv4        = v4_r && rdy_o;

  always_comb begin
    // channel check wins over the length check
    if (snap_chan == '0 || snap_chan > active_channels) begin
      status_c = ST_BAD_CHANNEL;
    end else if (32'(snap_count) != SAMPLES_PER_PULSE) begin
      status_c = ST_WRONG_LEN;
    end else begin
      status_c = ST_OK;
    end
    wt_c  = NET_MAG_W'(snap_area * BASELINE_WINDOW);
    sp_c  = NET_MAG_W'(snap_base * SAMPLES_PER_PULSE);
    net_c = $signed({1'b0, wt_c}) - $signed({1'b0, sp_c});
  end

  // w*q >= s*s always holds, so the difference stays non-negative
  assign spread_c = wq4_r - ss4_r;
  assign thr_sc_c = THR_SC_W'(pileup_threshold * (BASELINE_WINDOW * BASELINE_WINDOW));
  assign pile_c   = CMP_W'(spread_c) >= CMP_W'(thr_sc_c);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (mv3) begin
        v4_r <= 1'b1;
      end else if (rdy_o) begin
        v4_r <= 1'b0;
      end
      if (mv4) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mv3) begin
      stat4_r  <= status_c;
      chan4_r  <= snap_chan;
      peak4_r  <= snap_peak;
      floor4_r <= snap_floor;
      base4_r  <= snap_base;
      wq4_r    <= WQ_W'(snap_sq * BASELINE_WINDOW);
      ss4_r    <= WQ_W'(snap_base) * WQ_W'(snap_base);
      net4_r   <= net_c;
    end
    if (mv4) begin
      out_chan_r   <= chan4_r;
      out_status_r <= stat4_r;
      case (stat4_r)
        ST_OK: begin
          out_peak_r   <= peak4_r;
          out_floor_r  <= floor4_r;
          out_base_r   <= BASE_OUT_W'(base4_r);
          out_spread_r <= SPREAD_OUT_W'(spread_c);
          out_net_r    <= NET_OUT_W'(net4_r);
          out_pileup_r <= pile_c;
        end
        ST_WRONG_LEN: begin
          out_peak_r   <= '0;
          out_floor_r  <= SAMPLE_MAX;
          out_base_r   <= '0;
          out_spread_r <= '0;
          out_net_r    <= '0;
          out_pileup_r <= 1'b0;
        end
        default: begin
          out_peak_r   <= '0;
          out_floor_r  <= '0;
          out_base_r   <= '0;
          out_spread_r <= '0;
          out_net_r    <= '0;
          out_pileup_r <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_pulse_channel   = out_chan_r;
  assign out_status          = out_status_r;
  assign out_peak            = out_peak_r;
  assign out_floor           = out_floor_r;
  assign out_baseline_sum    = out_base_r;
  assign out_spread_scaled   = out_spread_r;
  assign out_net_area_scaled = out_net_r;
  assign out_pileup          = out_pileup_r;

  a_pileup_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_pileup_r |-> out_status_r == ST_OK)
    else $error("pile-up flagged on a rejected pulse");

  a_ok_peak_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ST_OK |-> out_floor_r <= out_peak_r)
    else $error("floor above peak on a good pulse");

endmodule

// ===== test/tb_adc_pulse_feature_extractor.sv =====
`timescale 1ns / 1ps
module tb_adc_pulse_feature_extractor;
  import apfe_pkg::*;

  localparam int PULSE_LEN      = 32;
  localparam int BASE_WIN       = 5;
  localparam int RESULT_LATENCY = 5;
  localparam int RANDOM_ITEMS   = 340;
  localparam int RANDOM_PULSES  = 12;
  localparam int PHASE_PULSES   = 6;
  localparam int LONG_HOLD      = 600;
  localparam int DIR_ROWS       = 19;

  // index with no register behind it, written to toggle the upper index bit
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [CHAN_W-1:0]       chan;
    status_t                 status;
    logic [SAMPLE_W-1:0]     peak;
    logic [SAMPLE_W-1:0]     minimum;
    logic [BASE_OUT_W-1:0]   base;
    logic [SPREAD_OUT_W-1:0] spread;
    logic [NET_OUT_W-1:0]    net;
    logic                    pileup;
  } pulse_feat_t;

  // typed = 1: the feature word is fixed in the table instead of predicted
  typedef struct packed {
    logic        typed;
    pulse_feat_t feat;
  } pulse_plan_t;

  typedef struct packed {
    logic                do_cfg;
    logic [7:0]          act;
    logic [7:0]          thr;
    logic [CHAN_W-1:0]   chan;
    logic [5:0]          len;
    logic [SAMPLE_W-1:0] base_v;
    logic [SAMPLE_W-1:0] body_v;
    logic                alt;
    logic                typed;
    pulse_feat_t         feat;
  } dir_row_t;

  // alt: odd baseline samples take the body value
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{0, 0, 0, 1, 32, 0, 0, 0, 1, '{1, ST_OK, 0, 0, 0, 0, 0, 0}},
    '{0, 0, 0, 63, 32, 1023, 1023, 0, 1, '{63, ST_OK, 1023, 1023, 5115, 0, 0, 0}},
    '{0, 0, 0, 2, 32, 1023, 0, 0, 1, '{2, ST_OK, 1023, 0, 5115, 0, -138105, 0}},
    '{0, 0, 0, 3, 32, 0, 1023, 0, 1, '{3, ST_OK, 1023, 0, 0, 0, 138105, 0}},
    '{0, 0, 0, 4, 32, 0, 1023, 1, 0, '0},
    '{0, 0, 0, 9, 32, 200, 700, 1, 0, '0},
    '{0, 0, 0, 0, 32, 5, 5, 0, 1, '{0, ST_BAD_CHANNEL, 0, 0, 0, 0, 0, 0}},
    '{0, 0, 0, 0, 3, 7, 9, 0, 1, '{0, ST_BAD_CHANNEL, 0, 0, 0, 0, 0, 0}},
    '{0, 0, 0, 5, 1, 1023, 1023, 0, 1, '{5, ST_WRONG_LEN, 0, 1023, 0, 0, 0, 0}},
    '{0, 0, 0, 6, 31, 300, 600, 0, 1, '{6, ST_WRONG_LEN, 0, 1023, 0, 0, 0, 0}},
    '{0, 0, 0, 7, 33, 300, 600, 0, 1, '{7, ST_WRONG_LEN, 0, 1023, 0, 0, 0, 0}},
    '{0, 0, 0, 8, 40, 0, 1023, 1, 1, '{8, ST_WRONG_LEN, 0, 1023, 0, 0, 0, 0}},
    '{1, 8'hc0, 0, 1, 32, 0, 0, 0, 1, '{1, ST_BAD_CHANNEL, 0, 0, 0, 0, 0, 0}},
    '{1, 63, 0, 1, 32, 100, 100, 0, 1, '{1, ST_OK, 100, 100, 500, 0, 0, 1}},
    '{0, 0, 0, 12, 32, 513, 2, 1, 0, '0},
    '{1, 10, 255, 10, 32, 0, 1023, 1, 0, '0},
    '{0, 0, 0, 11, 32, 0, 1023, 1, 1, '{11, ST_BAD_CHANNEL, 0, 0, 0, 0, 0, 0}},
    '{0, 0, 0, 10, 32, 500, 510, 1, 0, '0},
    '{1, 1, 24, 1, 32, 500, 510, 1, 0, '0}
  };

  logic                        clk;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [CHAN_W-1:0]           in_channel = '0;
  logic [SAMPLE_W-1:0]         in_sample = '0;
  logic                        in_last_sample = 1'b0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [CHAN_W-1:0]           out_pulse_channel;
  logic [STATUS_W-1:0]         out_status;
  logic [SAMPLE_W-1:0]         out_peak;
  logic [SAMPLE_W-1:0]         out_floor;
  logic [BASE_OUT_W-1:0]       out_baseline_sum;
  logic [SPREAD_OUT_W-1:0]     out_spread_scaled;
  logic signed [NET_OUT_W-1:0] out_net_area_scaled;
  logic                        out_pileup;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [CFG_DATA_W-1:0]       cfg_data = '0;

  // running pulse sums and register copies of the predictor
  logic [BASE_OUT_W-1:0] base_sum_q;
  logic [22:0]           sq_sum_q;
  logic [14:0]           area_sum_q;
  logic [SAMPLE_W-1:0]   peak_q;
  logic [SAMPLE_W-1:0]   min_q;
  logic [5:0]            count_q;
  logic [CHAN_W-1:0]     act_ch_q;
  logic [THR_W-1:0]      thr_q;

  pulse_feat_t pending_features[$];
  pulse_plan_t pulse_plans[$];
  int          mismatch_count = 0;
  bit          hold_req = 1'b0;

  adc_pulse_feature_extractor u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_channel          (in_channel),
    .in_sample           (in_sample),
    .in_last_sample      (in_last_sample),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_pulse_channel   (out_pulse_channel),
    .out_status          (out_status),
    .out_peak            (out_peak),
    .out_floor           (out_floor),
    .out_baseline_sum    (out_baseline_sum),
    .out_spread_scaled   (out_spread_scaled),
    .out_net_area_scaled (out_net_area_scaled),
    .out_pileup          (out_pileup),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("[adc_pulse_feature_extractor] ERROR");
    $finish;
  end

  task automatic flag_error(input string what, input longint got_v, input longint want_v);
    $display("%0t mismatch %s: got %0d want %0d", $time, what, got_v, want_v);
    mismatch_count++;
  endtask

  task automatic check_pulse(input pulse_feat_t want);
    if (out_pulse_channel !== want.chan)
      flag_error("pulse_channel", out_pulse_channel, want.chan);
    if (out_status !== want.status)
      flag_error("status", out_status, want.status);
    if (out_peak !== want.peak)
      flag_error("peak", out_peak, want.peak);
    if (out_floor !== want.minimum)
      flag_error("floor", out_floor, want.minimum);
    if (out_baseline_sum !== want.base)
      flag_error("baseline_sum", out_baseline_sum, want.base);
    if (out_spread_scaled !== want.spread)
      flag_error("spread_scaled", out_spread_scaled, want.spread);
    if (out_net_area_scaled !== want.net)
      flag_error("net_area_scaled", out_net_area_scaled, $signed(want.net));
    if (out_pileup !== want.pileup)
      flag_error("pileup", out_pileup, want.pileup);
  endtask

  task automatic clear_pulse();
    base_sum_q = '0;
    sq_sum_q   = '0;
    area_sum_q = '0;
    peak_q     = '0;
    min_q      = SAMPLE_MAX;
    count_q    = '0;
  endtask

  task automatic absorb_sample(input logic [SAMPLE_W-1:0] s);
    // samples past the nominal length are dropped, the count saturates one above
    if (count_q < PULSE_LEN) begin
      if (count_q < BASE_WIN) begin
        base_sum_q = base_sum_q + s;
        sq_sum_q   = sq_sum_q + {13'd0, s} * {13'd0, s};
      end
      area_sum_q = area_sum_q + s;
      if (peak_q <= s) peak_q = s;
      if (min_q >= s) min_q = s;
    end
    if (count_q < PULSE_LEN + 1) count_q = count_q + 1'b1;
  endtask

  function automatic pulse_feat_t close_pulse(input logic [CHAN_W-1:0] ch);
    pulse_feat_t f;
    longint      spread_l;
    longint      net_l;
    f = '0;
    f.chan = ch;
    if (ch == 0 || ch > act_ch_q) begin
      f.status = ST_BAD_CHANNEL;
    end else if (count_q != PULSE_LEN) begin
      f.status  = ST_WRONG_LEN;
      f.minimum = SAMPLE_MAX;
    end else begin
      spread_l  = BASE_WIN * longint'(sq_sum_q) - longint'(base_sum_q) * longint'(base_sum_q);
      net_l     = BASE_WIN * longint'(area_sum_q) - PULSE_LEN * longint'(base_sum_q);
      f.status  = ST_OK;
      f.peak    = peak_q;
      f.minimum = min_q;
      f.base    = base_sum_q;
      f.spread  = spread_l[SPREAD_OUT_W-1:0];
      f.net     = net_l[NET_OUT_W-1:0];
      f.pileup  = (spread_l >= longint'(thr_q) * BASE_WIN * BASE_WIN);
    end
    return f;
  endfunction

  always @(posedge clk) begin : monitor
    pulse_feat_t pred;
    pulse_feat_t want;
    pulse_plan_t plan;
    if (!rst_n) begin
      clear_pulse();
      act_ch_q = ACTIVE_CH_RST;
      thr_q    = PILEUP_THR_RST;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_features.size() == 0) begin
          flag_error("result with nothing pending, channel", out_pulse_channel, 0);
        end else begin
          want = pending_features.pop_front();
          check_pulse(want);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ACTIVE_CH:  act_ch_q = cfg_data[CHAN_W-1:0];
          CFG_PILEUP_THR: thr_q = cfg_data[THR_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        absorb_sample(in_sample);
        if (in_last_sample) begin
          pred = close_pulse(in_channel);
          clear_pulse();
          if (pulse_plans.size() != 0) begin
            plan = pulse_plans.pop_front();
            if (plan.typed) pred = plan.feat;
          end
          pending_features = {pending_features, pred};
        end
      end
    end
  end

  // result side: random ready runs and gaps, one long hold-off on request
  initial begin : receiver
    int  run;
    int  gap;
    int  r;
    bit  held;
    held = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 12);
        out_ready <= 1'b1;
        // a hold request cuts the current run short
        repeat (run) begin
          @(posedge clk);
          if (hold_req && !held) break;
        end
        r = $urandom_range(0, 19);
        if (r < 10) gap = 0;
        else if (r < 18) gap = $urandom_range(1, 3);
        else gap = $urandom_range(15, 60);
        if (gap > 0 && !(hold_req && !held)) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  function automatic int pick_gap(input bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 75) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_word(input logic [CHAN_W-1:0] ch, input logic [SAMPLE_W-1:0] s,
                           input logic last, input int gap);
    in_valid       <= 1'b1;
    in_channel     <= ch;
    in_sample      <= s;
    in_last_sample <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] act, input logic [7:0] thr);
    cfg_valid <= 1'b1;
    write_reg(CFG_ACTIVE_CH, act);
    write_reg(CFG_PILEUP_THR, thr);
    write_reg(CFG_UNUSED, CFG_DATA_W'($urandom_range(0, 255)));
    cfg_valid <= 1'b0;
  endtask

  // drain: every pulse closed and every feature word back, then the pipe empty
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pulse_plans.size() != 0 || pending_features.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY + 3) @(posedge clk);
  endtask

  initial begin : driver
    dir_row_t            row;
    pulse_plan_t         plan;
    logic [SAMPLE_W-1:0] smp;
    logic [CHAN_W-1:0]   ch;
    logic [CHAN_W-1:0]   cur_act;
    logic [7:0]          act_data;
    logic [7:0]          thr_data;
    bit                  burst;
    int                  i;
    int                  p;
    int                  len;
    int                  mode;
    int                  level;
    int                  tmp;
    int                  phase;
    int                  rand_items;
    int                  pulses;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIR_ROWS; r++) begin
      row = dir_rows[r];
      if (row.do_cfg) begin
        wait_idle();
        set_config(row.act, row.thr);
      end
      plan.typed = row.typed;
      plan.feat  = row.feat;
      pulse_plans = {pulse_plans, plan};
      burst = ($urandom_range(0, 2) == 0);
      for (i = 0; i < row.len; i++) begin
        smp = (i < BASE_WIN && !(row.alt && (i % 2 == 1))) ? row.base_v : row.body_v;
        send_word(row.chan, smp, (i == row.len - 1), pick_gap(burst));
      end
    end

    rand_items = 0;
    pulses     = 0;
    phase      = 0;
    while (rand_items < RANDOM_ITEMS || pulses < RANDOM_PULSES) begin
      wait_idle();
      case ($urandom_range(0, 4))
        0:       cur_act = 6'd63;
        1:       cur_act = 6'd0;
        2:       cur_act = 6'd1;
        default: cur_act = CHAN_W'($urandom_range(0, 63));
      endcase
      act_data = {2'($urandom_range(0, 3)), cur_act};
      case ($urandom_range(0, 3))
        0:       thr_data = 8'd0;
        1:       thr_data = 8'd255;
        2:       thr_data = 8'($urandom_range(0, 40));
        default: thr_data = 8'($urandom_range(0, 255));
      endcase
      set_config(act_data, thr_data);
      // one phase runs against a stalled receiver so the input backs up
      if (phase == 1) hold_req = 1'b1;

      for (p = 0; p < PHASE_PULSES; p++) begin
        case ($urandom_range(0, 9))
          8:       len = $urandom_range(1, 31);
          9:       len = $urandom_range(33, 45);
          default: len = PULSE_LEN;
        endcase
        if (cur_act != 0 && $urandom_range(0, 3) != 0) ch = CHAN_W'($urandom_range(1, cur_act));
        else ch = CHAN_W'($urandom_range(0, 63));
        mode  = $urandom_range(0, 3);
        level = $urandom_range(0, 1023);
        burst = ($urandom_range(0, 2) == 0);
        plan  = '0;
        pulse_plans = {pulse_plans, plan};
        for (i = 0; i < len; i++) begin
          case (mode)
            0: smp = SAMPLE_W'($urandom_range(0, 1023));
            1: smp = $urandom_range(0, 1) ? SAMPLE_MAX : '0;
            default: begin
              // quiet baseline around a level; mode 3 adds a pulse on top of it
              if (mode == 3 && i >= BASE_WIN) tmp = level + int'($urandom_range(0, 1023 - level));
              else tmp = level + int'($urandom_range(0, 6)) - 3;
              if (tmp < 0) tmp = 0;
              if (tmp > 1023) tmp = 1023;
              smp = tmp[SAMPLE_W-1:0];
            end
          endcase
          send_word((i == len - 1) ? ch : CHAN_W'($urandom_range(0, 63)), smp,
                    (i == len - 1), pick_gap(burst));
          rand_items++;
        end
        pulses++;
      end
      phase++;
    end

    wait_idle();
    repeat (RESULT_LATENCY * 4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[adc_pulse_feature_extractor] OK");
    end else begin
      $display("[adc_pulse_feature_extractor] ERROR");
    end
    $finish;
  end

endmodule
